[rtl/entity_id_allocator_mask_table_unit_assert.svh]
// ----------------------------------------------------------------------------
// entity table assertion macros
// shared property forms for the entity id allocator, clocked on clk and
// disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ENTITY_ID_ALLOCATOR_MASK_TABLE_UNIT_ASSERT_SVH
`define ENTITY_ID_ALLOCATOR_MASK_TABLE_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define EIDMT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define EIDMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/eidmt_pkg.sv]
// ----------------------------------------------------------------------------
// eidmt_pkg
// operation codes, status codes and table sizes of the entity table engine
// ----------------------------------------------------------------------------
package eidmt_pkg;

	// table size and derived widths
	localparam int ENTITY_CAPACITY = 1024;
	localparam int ID_W            = $clog2(ENTITY_CAPACITY);
	localparam int CNT_W           = ID_W + 1;
	localparam int RES_W           = 11;
	localparam int MASK_IN_W       = 32;
	localparam int KIND_W          = 3;
	localparam int STATUS_W        = 2;

	// operation selected by tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_CREATE  = 3'd0,
		KIND_DESTROY = 3'd1,
		KIND_WRITE   = 3'd2,
		KIND_HAS     = 3'd3,
		KIND_FIND    = 3'd4
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_OVERFLOW = 2'd2
	} status_t;

endpackage

[rtl/entity_id_allocator_mask_table_unit.sv]
// ----------------------------------------------------------------------------
// entity_id_allocator_mask_table_unit
// entity table engine: lifo free-list id allocator with one component mask
// per id, mask write, has test and find-next scan over the mask memory
// ----------------------------------------------------------------------------
// channel   dir  beat fields (lowest bit first)
// s_axis    in   tuser: kind[2:0]; tdata: entity_id[9:0], mask[41:10]
// m_axis    out  tdata: result_id[10:0], matched[11], status[13:12]
//
// after reset a clearing pass zeroes the mask memory with s_axis_tready low.
// create, destroy, write and has pass through the exec and resp states from
// accept to result. find-next scans upward from entity_id + 1; the scan reads
// the mask memory port once per cycle, each compare in the cycle after its read.
// one beat is in work at a time; the result register lets the next beat be
// accepted while the previous result waits on m_axis_tready.
// ----------------------------------------------------------------------------
`include "entity_id_allocator_mask_table_unit_assert.svh"

module entity_id_allocator_mask_table_unit
	import eidmt_pkg::*;
#(
	parameter int COMPONENT_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // entity_id[9:0], mask[41:10], zero fill
	input  logic [2:0]  s_axis_tuser,   // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // result_id[10:0], matched[11], status[13:12]
);

	localparam int MW = (COMPONENT_COUNT > MASK_IN_W) ? MASK_IN_W : COMPONENT_COUNT;
	localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(ENTITY_CAPACITY);
	localparam logic [ID_W-1:0]  LAST_C = ID_W'(ENTITY_CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_FIND,
		ST_RESP
	} state_t;

	state_t            state_q;
	logic [ID_W-1:0]   clr_q;
	kind_t             kind_q;
	logic [ID_W-1:0]   id_q;
	logic [MW-1:0]     query_q;
	logic [CNT_W-1:0]  free_cnt_q;
	logic [CNT_W-1:0]  fresh_q;
	logic [CNT_W-1:0]  scan_q;
	logic              chk_vld_s1;
	logic [CNT_W-1:0]  chk_id_s1;
	logic [RES_W-1:0]  res_id_q;
	logic              res_match_q;
	status_t           res_status_q;
	logic              m_valid_q;
	logic [15:0]       m_data_q;

	// memories and their ports
	logic [MW-1:0]     msk_mem [ENTITY_CAPACITY];
	logic [ID_W-1:0]   stk_mem [ENTITY_CAPACITY];
	logic [MW-1:0]     msk_rd_q;
	logic [ID_W-1:0]   stk_rd_q;
	logic              msk_we;
	logic [ID_W-1:0]   msk_waddr;
	logic [MW-1:0]     msk_wdata;
	logic [ID_W-1:0]   msk_raddr;
	logic              stk_we;
	logic [CNT_W-1:0]  cnt_dec;
	logic [ID_W-1:0]   stk_raddr;

	logic [ID_W-1:0]   s_id;
	logic [MW-1:0]     s_query;
	logic              holds;
	logic              out_free;

	// input beat fields
	assign s_id    = s_axis_tdata[ID_W-1:0];
	assign s_query = s_axis_tdata[ID_W +: MW];

	// handshake
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_free      = !m_valid_q || m_axis_tready;

	// shared mask compare, used by has and by the find scan
	assign holds = ((msk_rd_q & query_q) == query_q);

	// stack top address, read every cycle so it is ready after accept
	assign cnt_dec   = free_cnt_q - CNT_W'(1);
	assign stk_raddr = cnt_dec[ID_W-1:0];

	// mask read address: scan pointer while finding, else the incoming id
	assign msk_raddr = (state_q == ST_FIND) ? scan_q[ID_W-1:0] : s_id;

	// memory write controls
	always_comb begin
		msk_we    = 1'b0;
		msk_waddr = id_q;
		msk_wdata = '0;
		stk_we    = 1'b0;
		if (state_q == ST_CLEAR) begin
			msk_we    = 1'b1;
			msk_waddr = clr_q;
		end else if (state_q == ST_EXEC) begin
			case (kind_q)
				KIND_DESTROY: begin
					if (id_q != '0) begin
						msk_we = 1'b1;
						stk_we = (free_cnt_q < CAP_C);
					end
				end
				KIND_WRITE: begin
					msk_we    = 1'b1;
					msk_wdata = query_q;
				end
				default: begin
					msk_we = 1'b0;
				end
			endcase
		end
	end

	// mask memory
	always_ff @(posedge clk) begin
		if (msk_we) begin
			msk_mem[msk_waddr] <= msk_wdata;
		end
		msk_rd_q <= msk_mem[msk_raddr];
	end

	// free stack memory
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[free_cnt_q[ID_W-1:0]] <= id_q;
		end
		stk_rd_q <= stk_mem[stk_raddr];
	end

	// sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			kind_q       <= KIND_CREATE;
			id_q         <= '0;
			query_q      <= '0;
			free_cnt_q   <= '0;
			fresh_q      <= CNT_W'(1);
			scan_q       <= '0;
			chk_vld_s1   <= 1'b0;
			chk_id_s1    <= '0;
			res_id_q     <= '0;
			res_match_q  <= 1'b0;
			res_status_q <= STATUS_OK;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
		end else begin
			// beat taken downstream, unless a new result reloads it below
			if (m_valid_q && m_axis_tready && (state_q != ST_RESP)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ID_W'(1);
					if (clr_q == LAST_C) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q     <= kind_t'(s_axis_tuser);
						id_q       <= s_id;
						query_q    <= s_query;
						scan_q     <= {1'b0, s_id} + CNT_W'(1);
						chk_vld_s1 <= 1'b0;
						if (kind_t'(s_axis_tuser) == KIND_FIND) begin
							state_q <= ST_FIND;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					res_id_q     <= '0;
					res_match_q  <= 1'b0;
					res_status_q <= STATUS_OK;
					case (kind_q)
						KIND_CREATE: begin
							if (free_cnt_q != '0) begin
								res_id_q   <= RES_W'(stk_rd_q);
								free_cnt_q <= cnt_dec;
							end else if (fresh_q < CAP_C) begin
								res_id_q <= RES_W'(fresh_q);
								fresh_q  <= fresh_q + CNT_W'(1);
							end else begin
								res_status_q <= STATUS_FULL;
							end
						end
						KIND_DESTROY: begin
							if (id_q != '0) begin
								if (free_cnt_q < CAP_C) begin
									free_cnt_q <= free_cnt_q + CNT_W'(1);
								end else begin
									res_status_q <= STATUS_OVERFLOW;
								end
							end
						end
						KIND_HAS: begin
							res_match_q <= holds;
						end
						default: begin
							res_match_q <= 1'b0;
						end
					endcase
					state_q <= ST_RESP;
				end
				ST_FIND: begin
					// read issued for scan_q, compare on the entry read last cycle
					if (chk_vld_s1 && holds) begin
						res_id_q     <= RES_W'(chk_id_s1);
						res_match_q  <= 1'b1;
						res_status_q <= STATUS_OK;
						state_q      <= ST_RESP;
					end else if (!chk_vld_s1 && (scan_q == CAP_C)) begin
						res_id_q     <= RES_W'(CAP_C);
						res_match_q  <= 1'b0;
						res_status_q <= STATUS_OK;
						state_q      <= ST_RESP;
					end else begin
						chk_vld_s1 <= (scan_q < CAP_C);
						chk_id_s1  <= scan_q;
						if (scan_q < CAP_C) begin
							scan_q <= scan_q + CNT_W'(1);
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {2'b00, res_status_q, res_match_q, res_id_q};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`EIDMT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted twice without finishing")
	`EIDMT_ASSERT_SAME(a_free_cnt_bound, 1'b1, free_cnt_q <= CAP_C, "free stack count beyond capacity")
	`EIDMT_ASSERT_SAME(a_fresh_nonzero, 1'b1, fresh_q != '0 && fresh_q <= CAP_C, "fresh id out of range")
	`EIDMT_ASSERT_SAME(a_full_no_id, m_valid_q && m_data_q[13:12] == STATUS_FULL, m_data_q[10:0] == '0 && !m_data_q[11], "full create returned an id")

endmodule
